[sv/nhac_pkg.sv]
package nhac_pkg;

   localparam int CACHE_ENTRIES = 8;
   localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int IP_W = 32;
   localparam int MAC_W = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_OWN_IP      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;

   localparam logic OP_RESOLVE = 1'b0;
   localparam logic OP_LEARN   = 1'b1;

   typedef struct packed {
      logic             op;
      logic [IP_W-1:0]  dest_ip;
      logic [MAC_W-1:0] resolved_mac;
   } req_word_type;

   typedef struct packed {
      logic             hit;
      logic [IP_W-1:0]  hop_ip;
      logic             via_gateway;
      logic [MAC_W-1:0] hop_mac;
      logic [MAC_W-1:0] gateway_mac;
   } rsp_word_type;

   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IP_W-1:0]  hop;
      logic [MAC_W-1:0] mac;
   } token_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
   } wr_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_SEARCH = 3'b100
   } state_type;

endpackage

[sv/nhac_cell.sv]
module nhac_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [nhac_pkg::SLOT_W-1:0] cell_index,
   input  nhac_pkg::wr_type            wr,
   input  nhac_pkg::token_type         tok_in,
   output nhac_pkg::token_type         tok_out
);
   import nhac_pkg::*;

   logic [IP_W-1:0]  entry_ip_ff;
   logic [MAC_W-1:0] entry_mac_ff;
   logic             entry_valid_ff;
   token_type        tok_ff;
   token_type        tok_in_next;
   logic             wr_sel;
   logic             match;

   assign wr_sel = wr.en && (wr.slot == cell_index);
   assign match  = tok_in.valid && !tok_in.hit && entry_valid_ff
                   && (entry_ip_ff == tok_in.hop);

   always_comb begin
      tok_in_next = tok_in;
      if (match) begin
         tok_in_next.hit = 1'b1;
         tok_in_next.mac = entry_mac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         tok_ff.valid   <= 1'b0;
      end else begin
         if (wr_sel) begin
            entry_valid_ff <= 1'b1;
         end
         tok_ff.valid <= tok_in_next.valid;
      end
      if (wr_sel) begin
         entry_ip_ff  <= wr.ip;
         entry_mac_ff <= wr.mac;
      end
      tok_ff.hit <= tok_in_next.hit;
      tok_ff.hop <= tok_in_next.hop;
      tok_ff.mac <= tok_in_next.mac;
   end

   assign tok_out = tok_ff;

endmodule

[sv/next_hop_arp_cache.sv]
// Resolve: ST_EXEC, then ST_SEARCH while the token walks the cells; the strobe is registered.
// Learn: the entry is written in ST_EXEC; the result strobe is registered.
// A resolve walks the chain of entry cells, one cell per cycle; that chain length sets the rate.
// A new start is taken in the cycle its predecessor's result is shown; results cannot be stalled.
// Synchronous reset clears all entry valid bits, the fill slot, the gateway MAC and the registers.
module next_hop_arp_cache (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  nhac_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   output nhac_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nhac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nhac_pkg::IP_W-1:0]      csr_data
);
   import nhac_pkg::*;

   state_type         state_ff, state_in;
   logic              op_ff;
   logic [IP_W-1:0]   hop_ff;
   logic              local_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic [SLOT_W-1:0] fill_ff, fill_in;
   logic [MAC_W-1:0]  gw_mac_ff, gw_mac_in;
   logic [IP_W-1:0]   own_ip_ff, mask_ff, gw_ip_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;
   logic              accept;
   logic              local_hop;
   wr_type            wr;
   token_type         chain [0:CACHE_ENTRIES];

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign local_hop = (req_word.dest_ip & mask_ff) == (own_ip_ff & mask_ff);

   always_comb begin
      chain[0]       = '0;
      chain[0].valid = (state_ff == ST_EXEC) && (op_ff == OP_RESOLVE);
      chain[0].hop   = hop_ff;
   end

   always_comb begin
      wr      = '0;
      wr.en   = (state_ff == ST_EXEC) && (op_ff == OP_LEARN);
      wr.slot = fill_ff;
      wr.ip   = hop_ff;
      wr.mac  = mac_ff;
   end

   for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
      nhac_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_W'(i)),
         .wr         (wr),
         .tok_in     (chain[i]),
         .tok_out    (chain[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      gw_mac_in    = gw_mac_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_LEARN) begin
               fill_in = (fill_ff == SLOT_W'(CACHE_ENTRIES - 1)) ? '0 : fill_ff + 1'b1;
               if (!local_ff) begin
                  gw_mac_in = mac_ff;
               end
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = 1'b1;
               rsp_in.hop_ip      = hop_ff;
               rsp_in.via_gateway = !local_ff;
               rsp_in.hop_mac     = mac_ff;
               rsp_in.gateway_mac = local_ff ? gw_mac_ff : mac_ff;
               state_in           = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (chain[CACHE_ENTRIES].valid) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = chain[CACHE_ENTRIES].hit;
               rsp_in.hop_ip      = hop_ff;
               rsp_in.via_gateway = !local_ff;
               rsp_in.hop_mac     = chain[CACHE_ENTRIES].hit ? chain[CACHE_ENTRIES].mac : '0;
               rsp_in.gateway_mac = gw_mac_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         gw_mac_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         own_ip_ff    <= '0;
         mask_ff      <= '0;
         gw_ip_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         gw_mac_ff    <= gw_mac_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OWN_IP:      own_ip_ff <= csr_data;
               REG_SUBNET_MASK: mask_ff   <= csr_data;
               REG_GATEWAY_IP:  gw_ip_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff    <= req_word.op;
         local_ff <= local_hop;
         hop_ff   <= local_hop ? req_word.dest_ip : gw_ip_ff;
         mac_ff   <= req_word.resolved_mac;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
